[hw/rtl/bdlp_pkg.sv]
// ============================================================================
// bdlp_pkg
// Shared types and constants for the button debounce / long-press block.
// ============================================================================
package bdlp_pkg;

    // Counter widths
    localparam int SETTLE_BITS = 8;
    localparam int HOLD_BITS   = 16;

    // Configuration register widths and reset values
    localparam int DEBOUNCE_W    = 8;
    localparam int LONG_PRESS_W  = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [DEBOUNCE_W-1:0]   DEBOUNCE_RESET   = DEBOUNCE_W'(50);
    localparam logic [LONG_PRESS_W-1:0] LONG_PRESS_RESET = LONG_PRESS_W'(600);

    // Comparison widths, wide enough for either operand
    localparam int SETTLE_CMP_W = (SETTLE_BITS > DEBOUNCE_W) ? SETTLE_BITS : DEBOUNCE_W;
    localparam int HOLD_CMP_W   = (HOLD_BITS > LONG_PRESS_W) ? HOLD_BITS : LONG_PRESS_W;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEBOUNCE_TICKS   = 2'd0,
        CFG_LONG_PRESS_TICKS = 2'd1
    } cfg_index_t;

    // One tick word: raw active-low levels and the sleep request
    typedef struct packed {
        logic up_level;
        logic select_level;
        logic down_level;
        logic sleep_request;
    } tick_word_t;

    // One result word
    typedef struct packed {
        logic up_event;
        logic down_event;
        logic ok_event;
        logic back_event;
        logic wake_event;
        logic activity;
        logic display_awake;
    } result_word_t;

    // Status of one debounced button for the current tick
    typedef struct packed {
        logic settled;      // raw level has held long enough
        logic stable;       // stable level after this tick
        logic fell;         // stable level went to pressed this tick
    } btn_status_t;

endpackage

[hw/rtl/button_debounce_long_press_top.sv]
// ============================================================================
// button_debounce_long_press_top
// Debounces up, select and down; gives press, ok, back and wake events.
// ============================================================================
// A tick word passes through the input register and then the result register.
// Throughput: one tick word per cycle. The input register and the result
// register each hold one word; a stalled result keeps its word, so intake
// stops once the input register is also full.
// Reset: asynchronous active low; buttons released, settle counts at
// maximum, display awake, registers at 50 and 600 ticks.
module button_debounce_long_press_top
    import bdlp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // tick words
    input  logic                   tick_valid,
    output logic                   tick_ready,
    input  tick_word_t             tick,
    // result words
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_word_t           result
);

    // Configuration registers
    logic [DEBOUNCE_W-1:0]   debounce_reg;
    logic [LONG_PRESS_W-1:0] long_press_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEBOUNCE_TICKS:   debounce_reg   <= cfg_data[DEBOUNCE_W-1:0];
                CFG_LONG_PRESS_TICKS: long_press_reg <= cfg_data[LONG_PRESS_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register and handshake
    logic       in_valid_reg;
    tick_word_t in_word_reg;
    logic       fire;

    assign fire       = in_valid_reg && (!result_valid || result_ready);
    assign tick_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (tick_ready)
            in_valid_reg <= tick_valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick_ready && tick_valid)
            in_word_reg <= tick;
    end

    // Debouncers
    btn_status_t up_st;
    btn_status_t sel_st;
    btn_status_t dn_st;

    bdlp_debounce u_up (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (fire),
        .level          (in_word_reg.up_level),
        .debounce_ticks (debounce_reg),
        .status         (up_st)
    );

    bdlp_debounce u_sel (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (fire),
        .level          (in_word_reg.select_level),
        .debounce_ticks (debounce_reg),
        .status         (sel_st)
    );

    bdlp_debounce u_dn (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (fire),
        .level          (in_word_reg.down_level),
        .debounce_ticks (debounce_reg),
        .status         (dn_st)
    );

    // Press tracking state
    logic                 up_done_reg,   up_done_next;
    logic                 dn_done_reg,   dn_done_next;
    logic                 held_reg,      held_next;
    logic [HOLD_BITS-1:0] hold_cnt_reg,  hold_cnt_next;
    logic                 long_done_reg, long_done_next;
    logic                 asleep_reg,    asleep_next;

    logic                 up_ev_raw, dn_ev_raw;
    logic                 sel_down, sel_new, any_press;
    logic [HOLD_BITS-1:0] hold_inc;
    result_word_t         res_next;

    // Up/down: one event per debounced press
    always_comb
    begin
        up_done_next = up_st.fell ? 1'b0 : up_done_reg;
        up_ev_raw    = up_st.settled && !up_st.stable && !up_done_next;
        if (up_ev_raw)
            up_done_next = 1'b1;

        dn_done_next = dn_st.fell ? 1'b0 : dn_done_reg;
        dn_ev_raw    = dn_st.settled && !dn_st.stable && !dn_done_next;
        if (dn_ev_raw)
            dn_done_next = 1'b1;
    end

    // Select hold, long press and wake logic
    always_comb
    begin
        hold_inc = (held_reg && hold_cnt_reg != '1) ? hold_cnt_reg + HOLD_BITS'(1)
                                                    : hold_cnt_reg;
        sel_down  = !sel_st.stable;
        sel_new   = sel_down && !held_reg;
        any_press = up_ev_raw || dn_ev_raw || sel_new;

        held_next      = held_reg;
        hold_cnt_next  = hold_inc;
        long_done_next = long_done_reg;
        asleep_next    = asleep_reg;
        res_next       = '0;

        if (any_press && asleep_reg)
        begin
            // first press only wakes the display
            asleep_next         = 1'b0;
            res_next.wake_event = 1'b1;
            if (sel_new)
            begin
                held_next      = 1'b1;
                hold_cnt_next  = '0;
                long_done_next = 1'b1;
            end
        end
        else
        begin
            res_next.up_event   = up_ev_raw;
            res_next.down_event = dn_ev_raw;
            if (sel_new)
            begin
                held_next      = 1'b1;
                hold_cnt_next  = '0;
                long_done_next = 1'b0;
            end
            if (sel_down && held_next && !long_done_next &&
                HOLD_CMP_W'(hold_cnt_next) >= HOLD_CMP_W'(long_press_reg))
            begin
                res_next.back_event = 1'b1;
                long_done_next      = 1'b1;
            end
            if (!sel_down && held_next)
            begin
                res_next.ok_event = !long_done_next;
                held_next         = 1'b0;
            end
        end

        if (in_word_reg.sleep_request)
            asleep_next = 1'b1;

        res_next.activity      = any_press;
        res_next.display_awake = !asleep_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_done_reg   <= 1'b0;
            dn_done_reg   <= 1'b0;
            held_reg      <= 1'b0;
            hold_cnt_reg  <= '0;
            long_done_reg <= 1'b0;
            asleep_reg    <= 1'b0;
        end
        else if (fire)
        begin
            up_done_reg   <= up_done_next;
            dn_done_reg   <= dn_done_next;
            held_reg      <= held_next;
            hold_cnt_reg  <= hold_cnt_next;
            long_done_reg <= long_done_next;
            asleep_reg    <= asleep_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else if (fire)
            result_valid <= 1'b1;
        else if (result_ready)
            result_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            result <= res_next;
    end

endmodule

[hw/rtl/bdlp_debounce.sv]
// ============================================================================
// bdlp_debounce
// One button's settle counter, raw level and stable level.
// ============================================================================
module bdlp_debounce
    import bdlp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  level,
    input  logic [DEBOUNCE_W-1:0] debounce_ticks,
    output btn_status_t           status
);

    logic                   raw_reg;
    logic                   stable_reg;
    logic [SETTLE_BITS-1:0] count_reg;
    logic [SETTLE_BITS-1:0] count_next;
    logic                   settled;

    // Raw change restarts the count, otherwise count up and saturate
    always_comb
    begin
        if (level != raw_reg)
            count_next = '0;
        else if (count_reg != '1)
            count_next = count_reg + SETTLE_BITS'(1);
        else
            count_next = count_reg;
    end

    assign settled = SETTLE_CMP_W'(count_next) >= SETTLE_CMP_W'(debounce_ticks);

    // Status for this tick
    always_comb
    begin
        status.settled = settled;
        status.stable  = settled ? level : stable_reg;
        status.fell    = settled && (level != stable_reg) && !level;
    end

    // State update, one tick per enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg    <= 1'b1;
            stable_reg <= 1'b1;
            count_reg  <= '1;
        end
        else if (en)
        begin
            raw_reg    <= level;
            stable_reg <= status.stable;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/bdlp_checker.sv]
// ============================================================================
// bdlp_checker
// Port-level checks on the result words of the debounce block.
// ============================================================================
module bdlp_checker
    import bdlp_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         result_valid,
    input logic         result_ready,
    input result_word_t result
);

    // Stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // A waking press gives no action
    a_wake_swallow: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.wake_event |->
            !(result.up_event || result.down_event || result.ok_event ||
              result.back_event))
        else $error("action delivered with wake");

    // Ok and back never on the same word
    a_ok_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.ok_event && result.back_event))
        else $error("ok and back together");

    // Press and wake events imply activity
    a_activity: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.up_event || result.down_event || result.wake_event)
            |-> result.activity)
        else $error("event without activity");

endmodule

bind button_debounce_long_press_top bdlp_checker u_bdlp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
